// File: design/bft_pkg.sv
// Shared types, codes and defaults for the tape machine.
`default_nettype none
package bft_pkg;

  localparam int PROGRAM_DEPTH_DEF = 4096;
  localparam int TAPE_DEPTH_DEF    = 4096;

  localparam int ADDR_W = 12;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 13;
  localparam int STAT_W = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EXEC = 1'b1;

  localparam logic [STAT_W-1:0] ST_RUN  = 2'd0;
  localparam logic [STAT_W-1:0] ST_HALT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERR  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_INC = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DEC = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LFT = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_RGT = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_OUT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_INP = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_LBR = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBR = 8'h5D;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESP_HALT,
    S_RESP_SCAN
  } bft_state_t;

  typedef struct packed {
    logic clr_wr;
    logic load_wr;
    logic fetch;
    logic commit;
    logic scan_start;
    logic scan_step;
    logic emit_halt;
    logic emit_scan;
  } bft_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic halt_cond;
    logic jump_fwd;
    logic jump_bwd;
    logic scan_hit;
    logic scan_miss;
    logic out_free;
  } bft_stat_t;

endpackage
`default_nettype wire

// File: design/bf_tape_machine_top.sv
// Top level of the tape machine: control FSM plus datapath.
`default_nettype none
// After reset the tape is zeroed one cell a cycle with in_tready low; the
// length register may be written meanwhile. A load beat writes the program
// store from idle. An execute beat reads the program and the tape, then does
// a read-modify-write of the cell; one that finds the machine halted, or its
// pc at or past the length, goes through a halt response instead. A taken
// bracket jump walks the program store one byte a cycle through its single
// read port. Results wait in an output register; a stalled result holds the
// machine before it commits the next instruction. PROGRAM_DEPTH and
// TAPE_DEPTH must be powers of two; the block does not enforce this.
module bf_tape_machine_top #(
  parameter int PROGRAM_DEPTH = bft_pkg::PROGRAM_DEPTH_DEF,
  parameter int TAPE_DEPTH    = bft_pkg::TAPE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // address [11:0], program_char [19:12], zero pad [23:20]
  input  wire logic [bft_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind [0]
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_byte [7:0], status [9:8], zero pad [15:10]
  output logic [bft_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_valid [0]
  output logic                                 out_tuser,
  input  wire logic                            cfg_we,
  input  wire logic [bft_pkg::LEN_W-1:0]       cfg_wdata
);
  import bft_pkg::*;

  bft_cmd_t  cmd;
  bft_stat_t stat;

  bft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bft_dpath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .TAPE_DEPTH    (TAPE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// File: design/bft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/bft_ctrl.sv
// Sequencing state machine for the tape machine.
`default_nettype none
module bft_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_kind,
  output logic                     in_tready,
  input  wire bft_pkg::bft_stat_t  stat,
  output bft_pkg::bft_cmd_t        cmd
);
  import bft_pkg::*;

  bft_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load_wr = 1'b1;
          end else if (stat.halt_cond) begin
            state_nxt = S_RESP_HALT;
          end else begin
            cmd.fetch = 1'b1;
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (stat.jump_fwd || stat.jump_bwd) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit || stat.scan_miss) begin
          state_nxt = S_RESP_SCAN;
        end
      end
      S_RESP_HALT: begin
        if (stat.out_free) begin
          cmd.emit_halt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RESP_SCAN: begin
        if (stat.out_free) begin
          cmd.emit_scan = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/bft_dpath.sv
// Datapath: program store, tape, pointers, bracket scanner and result register.
`default_nettype none
module bft_dpath #(
  parameter int PROGRAM_DEPTH = bft_pkg::PROGRAM_DEPTH_DEF,
  parameter int TAPE_DEPTH    = bft_pkg::TAPE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [bft_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [bft_pkg::LEN_W-1:0]       cfg_wdata,
  input  wire bft_pkg::bft_cmd_t               cmd,
  output bft_pkg::bft_stat_t                   stat,
  input  wire logic                            out_tready,
  output logic                                 out_tvalid,
  output logic [bft_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tuser
);
  import bft_pkg::*;

  localparam int PA_W  = $clog2(PROGRAM_DEPTH);
  localparam int PC_W  = $clog2(PROGRAM_DEPTH + 1);
  localparam int TA_W  = $clog2(TAPE_DEPTH);
  localparam int CMP_W = (PC_W > LEN_W) ? PC_W : LEN_W;
  localparam logic [CMP_W-1:0] PDEPTH_C = CMP_W'(PROGRAM_DEPTH);
  localparam logic [TA_W-1:0]  DP_MAX   = TA_W'(TAPE_DEPTH - 1);

  logic [PC_W-1:0]   len_r, pc_r, ip_r, pos_r, depth_r, tgt_r;
  logic [PC_W-1:0]   len_nxt, pc_nxt, ip_nxt, pos_nxt, depth_nxt, tgt_nxt;
  logic [TA_W-1:0]   dp_r, dp_nxt, clr_idx_r, clr_idx_nxt;
  logic              halted_r, halted_nxt;
  logic              dir_r, dir_nxt, more_r, more_nxt, pend_r, pend_nxt;
  logic              found_r, found_nxt;
  logic              oval_r, oval_nxt, oflag_r, oflag_nxt;
  logic [CHAR_W-1:0] obyte_r, obyte_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;

  logic [CMP_W-1:0]  cfg_ext;
  logic [CHAR_W-1:0] prog_rdata, tape_rdata, tape_wdata;
  logic [PA_W-1:0]   prog_waddr, prog_raddr;
  logic              prog_re, tape_we;
  logic [TA_W-1:0]   tape_waddr;
  logic              is_inc, is_match, hit;
  logic [PC_W-1:0]   ip_up;

  assign cfg_ext = CMP_W'(cfg_wdata);

  assign prog_waddr = PA_W'(in_tdata[ADDR_W-1:0]);
  assign prog_raddr = cmd.scan_step ? PA_W'(ip_r) : PA_W'(pc_r);
  assign prog_re    = cmd.fetch || (cmd.scan_step && more_r);

  bft_ram #(.WIDTH(CHAR_W), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (prog_waddr),
    .wdata (in_tdata[ADDR_W +: CHAR_W]),
    .re    (prog_re),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  assign tape_we    = cmd.clr_wr ||
                      (cmd.commit && (prog_rdata == CH_INC || prog_rdata == CH_DEC));
  assign tape_waddr = cmd.clr_wr ? clr_idx_r : dp_r;
  assign tape_wdata = cmd.clr_wr ? '0 :
                      (prog_rdata == CH_INC) ? tape_rdata + 8'd1 : tape_rdata - 8'd1;

  bft_ram #(.WIDTH(CHAR_W), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .re    (cmd.fetch),
    .raddr (dp_r),
    .rdata (tape_rdata)
  );

  assign is_inc   = dir_r ? (prog_rdata == CH_LBR) : (prog_rdata == CH_RBR);
  assign is_match = dir_r ? (prog_rdata == CH_RBR) : (prog_rdata == CH_LBR);
  assign hit      = pend_r && is_match && (depth_r == '0);
  assign ip_up    = ip_r + 1'b1;

  always_comb begin
    stat           = '0;
    stat.clr_last  = (clr_idx_r == DP_MAX);
    stat.halt_cond = halted_r || (pc_r >= len_r);
    stat.jump_fwd  = (prog_rdata == CH_LBR) && (tape_rdata == '0);
    stat.jump_bwd  = (prog_rdata == CH_RBR) && (tape_rdata != '0);
    stat.scan_hit  = hit;
    stat.scan_miss = !pend_r && !more_r;
    stat.out_free  = !oval_r || out_tready;
  end

  always_comb begin
    len_nxt     = len_r;
    pc_nxt      = pc_r;
    dp_nxt      = dp_r;
    halted_nxt  = halted_r;
    clr_idx_nxt = clr_idx_r;
    ip_nxt      = ip_r;
    pos_nxt     = pos_r;
    depth_nxt   = depth_r;
    tgt_nxt     = tgt_r;
    dir_nxt     = dir_r;
    more_nxt    = more_r;
    pend_nxt    = pend_r;
    found_nxt   = found_r;
    oval_nxt    = oval_r && !out_tready;
    oflag_nxt   = oflag_r;
    obyte_nxt   = obyte_r;
    ostat_nxt   = ostat_r;

    if (cfg_we) begin
      len_nxt = (cfg_ext > PDEPTH_C) ? PC_W'(PROGRAM_DEPTH) : PC_W'(cfg_ext);
    end
    if (cmd.clr_wr) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
    end

    if (cmd.commit) begin
      pc_nxt    = pc_r + 1'b1;
      oval_nxt  = 1'b1;
      oflag_nxt = (prog_rdata == CH_OUT);
      obyte_nxt = (prog_rdata == CH_OUT) ? tape_rdata : '0;
      ostat_nxt = ST_RUN;
      unique case (prog_rdata)
        CH_LFT:  dp_nxt = (dp_r == '0) ? DP_MAX : dp_r - 1'b1;
        CH_RGT:  dp_nxt = (dp_r == DP_MAX) ? '0 : dp_r + 1'b1;
        default: dp_nxt = dp_r;
      endcase
    end

    if (cmd.scan_start) begin
      dir_nxt   = (prog_rdata == CH_LBR);
      pend_nxt  = 1'b0;
      depth_nxt = '0;
      found_nxt = 1'b0;
      if (prog_rdata == CH_LBR) begin
        ip_nxt   = pc_r + 1'b1;
        more_nxt = (pc_r + 1'b1) < len_r;
      end else begin
        ip_nxt   = pc_r - 1'b1;
        more_nxt = (pc_r != '0);
      end
    end

    if (cmd.scan_step) begin
      pend_nxt = more_r;
      if (more_r) begin
        pos_nxt = ip_r;
        if (dir_r) begin
          ip_nxt   = ip_up;
          more_nxt = ip_up < len_r;
        end else begin
          ip_nxt   = ip_r - 1'b1;
          more_nxt = (ip_r != '0);
        end
      end
      if (hit) begin
        found_nxt = 1'b1;
        tgt_nxt   = pos_r + 1'b1;
        more_nxt  = 1'b0;
        pend_nxt  = 1'b0;
      end else if (pend_r) begin
        if (is_inc) begin
          depth_nxt = depth_r + 1'b1;
        end else if (is_match) begin
          depth_nxt = depth_r - 1'b1;
        end
      end
    end

    if (cmd.emit_halt) begin
      halted_nxt = 1'b1;
      oval_nxt   = 1'b1;
      oflag_nxt  = 1'b0;
      obyte_nxt  = '0;
      ostat_nxt  = ST_HALT;
    end

    if (cmd.emit_scan) begin
      oval_nxt  = 1'b1;
      oflag_nxt = 1'b0;
      obyte_nxt = '0;
      ostat_nxt = found_r ? ST_RUN : ST_ERR;
      if (found_r) begin
        pc_nxt = tgt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      pc_r      <= '0;
      dp_r      <= '0;
      halted_r  <= 1'b0;
      clr_idx_r <= '0;
      more_r    <= 1'b0;
      pend_r    <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      len_r     <= len_nxt;
      pc_r      <= pc_nxt;
      dp_r      <= dp_nxt;
      halted_r  <= halted_nxt;
      clr_idx_r <= clr_idx_nxt;
      more_r    <= more_nxt;
      pend_r    <= pend_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_r    <= ip_nxt;
    pos_r   <= pos_nxt;
    depth_r <= depth_nxt;
    tgt_r   <= tgt_nxt;
    dir_r   <= dir_nxt;
    found_r <= found_nxt;
    oflag_r <= oflag_nxt;
    obyte_r <= obyte_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tuser  = oflag_r;
  assign out_tdata  = OUT_TDATA_W'({ostat_r, obyte_r});

endmodule
`default_nettype wire
